/* design/xxh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_pkg
// Shared constants, types and helper functions of the 32-bit xxHash engine.
// ----------------------------------------------------------------------------
package xxh_pkg;

	// Number of lane accumulators, one per word of a stripe.
	localparam int LANES = 4;

	// Primes of the scheme.
	localparam logic [31:0] PRIME1 = 32'd2654435761;
	localparam logic [31:0] PRIME2 = 32'd2246822519;
	localparam logic [31:0] PRIME3 = 32'd3266489917;
	localparam logic [31:0] PRIME4 = 32'd668265263;
	localparam logic [31:0] PRIME5 = 32'd374761393;

	// Bytes in one full stripe.
	localparam logic [4:0] STRIPE_BYTES = 5'd16;

	// Control from the top level to each lane.
	typedef struct packed {
		logic capture;  // a beat is accepted: register word * PRIME2
		logic step;     // apply one round to the accumulator
		logic load;     // start from the seed-derived value, not the accumulator
	} lane_ctl_t;

	// Rotate left by a constant amount.
	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		rotl = (x << r) | (x >> (32 - r));
	endfunction

	// Starting value of a lane accumulator for a given seed.
	function automatic logic [31:0] lane_init(input logic [31:0] seed, input logic [1:0] idx);
		logic [31:0] v;
		case (idx)
			2'd0: v = seed + PRIME1 + PRIME2;
			2'd1: v = seed + PRIME2;
			2'd2: v = seed;
			default: v = seed - PRIME1;
		endcase
		lane_init = v;
	endfunction

endpackage
`default_nettype wire

/* design/xxh_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_if
// Valid/ready channels of the hash engine: stripe input and hash output.
// ----------------------------------------------------------------------------

// One stripe of up to sixteen message bytes per beat.
interface xxh_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] word0;
	logic [31:0] word1;
	logic [31:0] word2;
	logic [31:0] word3;
	logic [4:0]  byte_count;
	logic        last;

	modport source (output valid, output word0, output word1, output word2, output word3,
		output byte_count, output last, input ready);
	modport sink (input valid, input word0, input word1, input word2, input word3,
		input byte_count, input last, output ready);
endinterface

// One finished hash per beat.
interface xxh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash;

	modport source (output valid, output hash, input ready);
	modport sink (input valid, input hash, output ready);
endinterface
`default_nettype wire

/* design/xxh_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_lane
// One lane accumulator: a product stage followed by the add, rotate and
// multiply round that updates the accumulator.
// ----------------------------------------------------------------------------
module xxh_lane (
	input  wire logic               clk,
	input  wire xxh_pkg::lane_ctl_t ctl,
	input  wire logic [31:0]        word,
	input  wire logic [31:0]        init,
	output logic [31:0]             acc
);

	logic [31:0] prod_s1;
	logic [31:0] acc_q;
	logic [31:0] base;
	logic [31:0] sum;

	// First stage: word times PRIME2, independent of the accumulator.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			prod_s1 <= word * xxh_pkg::PRIME2;
		end
	end

	// Round: acc = rotl(acc + prod, 13) * PRIME1.
	always_comb begin
		base = ctl.load ? init : acc_q;
		sum  = base + prod_s1;
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			acc_q <= xxh_pkg::rotl(sum, 13) * xxh_pkg::PRIME1;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

/* design/xxh_fin.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh_fin
// Finalization sequencer: merges the lanes, runs the word and byte tail
// rounds and the avalanche on one shared multiplier, and holds the result.
// ----------------------------------------------------------------------------
module xxh_fin (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic        seen,
	input  wire logic [31:0] seed,
	input  wire logic [31:0] len,
	input  wire logic [31:0] lanes [xxh_pkg::LANES],
	input  wire logic [31:0] words [xxh_pkg::LANES],
	input  wire logic [3:0]  tail_cnt,
	output logic             done,
	xxh_out_if.source        result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TAIL = 3'd1;
	localparam logic [2:0] ST_TMUL = 3'd2;
	localparam logic [2:0] ST_AV1  = 3'd3;
	localparam logic [2:0] ST_AV2  = 3'd4;
	localparam logic [2:0] ST_AV3  = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] h_q;
	logic [3:0]  pos_q;
	logic        word_mode_q;
	logic        out_valid_q;
	logic [31:0] hash_q;

	logic [3:0]  rem;
	logic [31:0] sel_word;
	logic [7:0]  sel_byte;
	logic [31:0] merged;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic        out_free;

	// Operand selection for the tail rounds.
	always_comb begin
		rem      = tail_cnt - pos_q;
		sel_word = words[pos_q[3:2]];
		sel_byte = 8'(sel_word >> {pos_q[1:0], 3'b000});
		out_free = !out_valid_q || result.ready;
	end

	// Lane merge, or the seed path when no stripe was absorbed, plus length.
	always_comb begin
		if (seen) begin
			merged = xxh_pkg::rotl(lanes[0], 1) + xxh_pkg::rotl(lanes[1], 7)
				+ xxh_pkg::rotl(lanes[2], 12) + xxh_pkg::rotl(lanes[3], 18);
		end else begin
			merged = seed + xxh_pkg::PRIME5;
		end
		merged = merged + len;
	end

	// Shared multiplier, operands chosen by the step in progress.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TAIL: begin
				if (rem >= 4'd4) begin
					mul_a = sel_word;
					mul_b = xxh_pkg::PRIME3;
				end else begin
					mul_a = {24'd0, sel_byte};
					mul_b = xxh_pkg::PRIME5;
				end
			end
			ST_TMUL: begin
				if (word_mode_q) begin
					mul_a = xxh_pkg::rotl(h_q, 17);
					mul_b = xxh_pkg::PRIME4;
				end else begin
					mul_a = xxh_pkg::rotl(h_q, 11);
					mul_b = xxh_pkg::PRIME1;
				end
			end
			ST_AV1: begin
				mul_a = h_q ^ (h_q >> 15);
				mul_b = xxh_pkg::PRIME2;
			end
			ST_AV2: begin
				mul_a = h_q ^ (h_q >> 13);
				mul_b = xxh_pkg::PRIME3;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = mul_a * mul_b;
	end

	// Sequencer state and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			word_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new hash enters the output register as the old one leaves.
			if ((state_q == ST_AV3) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						pos_q   <= '0;
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (rem >= 4'd4) begin
						word_mode_q <= 1'b1;
						state_q     <= ST_TMUL;
					end else if (rem != 4'd0) begin
						word_mode_q <= 1'b0;
						state_q     <= ST_TMUL;
					end else begin
						state_q <= ST_AV1;
					end
				end
				ST_TMUL: begin
					pos_q   <= pos_q + (word_mode_q ? 4'd4 : 4'd1);
					state_q <= ST_TAIL;
				end
				ST_AV1: begin
					state_q <= ST_AV2;
				end
				ST_AV2: begin
					state_q <= ST_AV3;
				end
				ST_AV3: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Running hash value and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					h_q <= merged;
				end
			end
			ST_TAIL: begin
				if (rem != 4'd0) begin
					h_q <= h_q + prod;
				end
			end
			ST_TMUL, ST_AV1, ST_AV2: begin
				h_q <= prod;
			end
			ST_AV3: begin
				if (out_free) begin
					hash_q <= h_q ^ (h_q >> 16);
				end
			end
			default: begin
				h_q <= h_q;
			end
		endcase
	end

	assign done         = (state_q == ST_AV3) && out_free;
	assign result.valid = out_valid_q;
	assign result.hash  = hash_q;

endmodule
`default_nettype wire

/* design/xxh32_stream_hash.sv */
`timescale 1ns / 1ps
`default_nettype none
// Stripes that are not last are taken one per cycle while no last beat is being hashed;
// each goes through the product stage into the lane accumulators. A last beat is hashed
// in R tail rounds (count/4 word rounds plus count%4 byte rounds for a short tail, none
// for a full stripe), run by the single finalization sequencer on its shared multiplier;
// no beat is taken from a last beat until its hash sits in the output register.
// Reset clears the seed, the length, the stripe flag and all handshake state.
// ----------------------------------------------------------------------------
// xxh32_stream_hash
// 32-bit xxHash over 16-byte stripes with four parallel lane accumulators
// and a finalization sequencer.
// ----------------------------------------------------------------------------
module xxh32_stream_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	xxh_in_if.sink           stripe,
	xxh_out_if.source        result
);

	logic [31:0] seed_q;
	logic [31:0] len_q;
	logic        seen_q;
	logic        busy_q;
	logic        go_q;
	logic        valid_s1;
	logic        absorb_s1;
	logic        last_s1;
	logic [3:0]  tail_cnt_s1;
	logic [31:0] word_s1 [xxh_pkg::LANES];

	logic        accept;
	logic [4:0]  count_sat;
	logic        full_last;
	logic [31:0] in_word [xxh_pkg::LANES];
	logic [31:0] lane_acc [xxh_pkg::LANES];
	xxh_pkg::lane_ctl_t lane_ctl;
	logic        fin_done;

	// Input side decode.
	assign stripe.ready = !busy_q;
	assign accept       = stripe.valid && stripe.ready;
	assign in_word[0]   = stripe.word0;
	assign in_word[1]   = stripe.word1;
	assign in_word[2]   = stripe.word2;
	assign in_word[3]   = stripe.word3;

	always_comb begin
		count_sat = (stripe.byte_count > xxh_pkg::STRIPE_BYTES) ? xxh_pkg::STRIPE_BYTES
			: stripe.byte_count;
		full_last = (count_sat == xxh_pkg::STRIPE_BYTES);
	end

	// Seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// Message control: length, stripe flag, busy and the stage-one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			seen_q    <= 1'b0;
			busy_q    <= 1'b0;
			go_q      <= 1'b0;
			valid_s1  <= 1'b0;
			absorb_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			go_q     <= valid_s1 && last_s1;
			if (accept) begin
				absorb_s1 <= !stripe.last || full_last;
				last_s1   <= stripe.last;
				len_q     <= len_q + (stripe.last ? {27'd0, count_sat}
					: {27'd0, xxh_pkg::STRIPE_BYTES});
				if (stripe.last) begin
					busy_q <= 1'b1;
				end
			end
			if (valid_s1 && absorb_s1) begin
				seen_q <= 1'b1;
			end
			if (go_q) begin
				len_q  <= '0;
				seen_q <= 1'b0;
			end
			if (fin_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Tail payload, held until the hash is finished.
	always_ff @(posedge clk) begin
		if (accept) begin
			tail_cnt_s1 <= full_last ? 4'd0 : count_sat[3:0];
			for (int i = 0; i < xxh_pkg::LANES; i++) begin
				word_s1[i] <= in_word[i];
			end
		end
	end

	// Lane array.
	always_comb begin
		lane_ctl.capture = accept;
		lane_ctl.step    = valid_s1 && absorb_s1;
		lane_ctl.load    = !seen_q;
	end

	for (genvar g = 0; g < xxh_pkg::LANES; g++) begin : g_lane
		xxh_lane u_lane (
			.clk  (clk),
			.ctl  (lane_ctl),
			.word (in_word[g]),
			.init (xxh_pkg::lane_init(seed_q, 2'(g))),
			.acc  (lane_acc[g])
		);
	end

	// Merge, tail rounds and avalanche.
	xxh_fin u_fin (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.seen     (seen_q),
		.seed     (seed_q),
		.len      (len_q),
		.lanes    (lane_acc),
		.words    (word_s1),
		.tail_cnt (tail_cnt_s1),
		.done     (fin_done),
		.result   (result)
	);

`ifndef SYNTH
	// A finished hash only ever closes a message in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_done |-> busy_q) else $error("hash finished with no message in progress");

	// A last beat in stage one starts the finalization in the next cycle.
	a_last_go: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> go_q) else $error("last beat did not start merge");

	// No stripe may still be updating the lanes while they are merged.
	a_go_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> (!valid_s1 && busy_q)) else $error("lanes busy during merge");

	// Message state is cleared once the merge has read it.
	a_go_clear: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |=> (!seen_q && len_q == 32'd0)) else $error("message state not cleared");
`endif

endmodule
`default_nettype wire

/* bench/xxh32_stream_hash_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh32_stream_hash_test
// Self-checking bench for the streaming 32-bit xxHash engine. Messages of
// random length and content are sent under several seeds. The bench keeps
// its own model of the lanes, the length and the finalization. Every hash
// that comes out is compared with the oldest hash that the model predicts.
// ----------------------------------------------------------------------------

// Tracks the hash state of the message in flight and queues each finished digest.
class xxh_board;
	localparam logic [31:0] P1 = 32'd2654435761;
	localparam logic [31:0] P2 = 32'd2246822519;
	localparam logic [31:0] P3 = 32'd3266489917;
	localparam logic [31:0] P4 = 32'd668265263;
	localparam logic [31:0] P5 = 32'd374761393;

	logic [31:0] seed;
	logic [31:0] lane [4];
	logic [31:0] msg_bytes;
	bit          lanes_live;
	logic [31:0] want_hash [$];
	int          errors;

	function new();
		seed = '0;
		msg_bytes = '0;
		lanes_live = 1'b0;
		errors = 0;
		foreach (lane[i]) lane[i] = '0;
	endfunction

	function logic [31:0] rot(input logic [31:0] x, input int r);
		logic [63:0] both;
		both = {x, x} << r;
		return both[63:32];
	endfunction

	// A full stripe: load the lanes from the seed on the first one, then one round per lane.
	function void absorb(input logic [31:0] w [4]);
		if (!lanes_live) begin
			lane[0] = seed + P1 + P2;
			lane[1] = seed + P2;
			lane[2] = seed;
			lane[3] = seed - P1;
			lanes_live = 1'b1;
		end
		foreach (lane[i]) lane[i] = rot(lane[i] + w[i] * P2, 13) * P1;
	endfunction

	// Called for every accepted input beat.
	function void take_stripe(input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w2, input logic [31:0] w3,
			input logic [4:0] cnt, input logic lst);
		logic [31:0] w [4];
		logic [31:0] h;
		logic [31:0] b;
		int n;
		int nw;
		int i;
		w = '{w0, w1, w2, w3};
		if (!lst) begin
			absorb(w);
			msg_bytes += 32'd16;
			return;
		end
		// Counts above sixteen saturate.
		n = (cnt > 5'd16) ? 16 : int'(cnt);
		msg_bytes += n;
		if (n == 16) begin
			absorb(w);
			n = 0;
		end
		if (lanes_live)
			h = rot(lane[0], 1) + rot(lane[1], 7) + rot(lane[2], 12) + rot(lane[3], 18);
		else
			h = seed + P5;
		h += msg_bytes;
		// Whole words of the tail first, then the leftover bytes one at a time.
		nw = n / 4;
		for (i = 0; i < nw; i++)
			h = rot(h + w[i] * P3, 17) * P4;
		for (i = nw * 4; i < n; i++) begin
			b = (w[i / 4] >> ((i % 4) * 8)) & 32'hFF;
			h = rot(h + b * P5, 11) * P1;
		end
		// Avalanche.
		h ^= h >> 15;
		h *= P2;
		h ^= h >> 13;
		h *= P3;
		h ^= h >> 16;
		want_hash.push_back(h);
		msg_bytes = '0;
		lanes_live = 1'b0;
	endfunction

	// Called for every accepted result beat.
	function void check_hash(input logic [31:0] got);
		logic [31:0] exp_h;
		if (want_hash.size() == 0) begin
			$display("%0t: hash %h arrived with none expected", $time, got);
			errors++;
			return;
		end
		exp_h = want_hash.pop_front();
		if (got !== exp_h) begin
			$display("%0t: hash mismatch: expected %h, actual %h", $time, exp_h, got);
			errors++;
		end
	endfunction
endclass

module xxh32_stream_hash_test;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	xxh_in_if  stripe_if ();
	xxh_out_if hash_if ();

	xxh32_stream_hash dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stripe    (stripe_if),
		.result    (hash_if)
	);

	xxh_board board;
	bit       idling = 1'b1;
	bit       hold_req = 1'b0;
	int       hold_len = 400;
	int       beats_sent = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit.
	initial begin
		#10_000_000;
		$display("xxh32_stream_hash_test: FAIL");
		$finish;
	end

	// Watch both channels; every handshake goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && stripe_if.valid && stripe_if.ready)
			board.take_stripe(stripe_if.word0, stripe_if.word1, stripe_if.word2,
				stripe_if.word3, stripe_if.byte_count, stripe_if.last);
		if (arst_n && hash_if.valid && hash_if.ready)
			board.check_hash(hash_if.hash);
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		hash_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hash_if.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_req = 1'b0;
			end
			hash_if.ready <= !(idling && $urandom_range(99) < 23);
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Offer one beat and hold it until it is taken.
	task automatic send_stripe(input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w2, input logic [31:0] w3,
			input logic [4:0] cnt, input logic lst);
		while (idling && $urandom_range(99) < 23) begin
			stripe_if.valid <= 1'b0;
			@(posedge clk);
		end
		stripe_if.valid      <= 1'b1;
		stripe_if.word0      <= w0;
		stripe_if.word1      <= w1;
		stripe_if.word2      <= w2;
		stripe_if.word3      <= w3;
		stripe_if.byte_count <= cnt;
		stripe_if.last       <= lst;
		do @(posedge clk); while (!stripe_if.ready);
		beats_sent++;
	endtask

	// Change the seed once the engine has drained.
	task automatic write_seed(input logic [31:0] v);
		stripe_if.valid <= 1'b0;
		@(posedge clk);
		while (board.want_hash.size() != 0) @(posedge clk);
		// Let the last stripe reach the lanes and any tail finish.
		repeat (30) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.seed = v;
	endtask

	// A message of nstr full stripes and a closing beat; optionally a new seed
	// after stripe number seed_at.
	task automatic send_message(input int nstr, input logic [4:0] cnt, input int seed_at);
		int i;
		for (i = 1; i <= nstr; i++) begin
			send_stripe(rand_word(), rand_word(), rand_word(), rand_word(),
				5'($urandom_range(31)), 1'b0);
			if (i == seed_at)
				write_seed($urandom());
		end
		send_stripe(rand_word(), rand_word(), rand_word(), rand_word(), cnt, 1'b1);
	endtask

	// Main sequence.
	initial begin
		int m;
		int nstr;
		int pick;
		int w;
		logic [4:0] cnt;
		board = new();
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		stripe_if.valid      <= 1'b0;
		stripe_if.word0      <= '0;
		stripe_if.word1      <= '0;
		stripe_if.word2      <= '0;
		stripe_if.word3      <= '0;
		stripe_if.byte_count <= '0;
		stripe_if.last       <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message under the reset seed: no stripe, no tail.
		send_stripe('0, '0, '0, '0, 5'd0, 1'b1);
		// A single full stripe as the closing beat, all ones.
		write_seed(32'hFFFF_FFFF);
		send_stripe('1, '1, '1, '1, 5'd16, 1'b1);
		// Short tails of various lengths.
		send_stripe(32'hFFFF_FFFF, $urandom(), $urandom(), $urandom(), 5'd1, 1'b1);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd3, 1'b1);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd4, 1'b1);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd7, 1'b1);
		send_stripe('1, '1, '1, '1, 5'd15, 1'b1);
		// Counts past sixteen saturate.
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd17, 1'b1);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd31, 1'b1);
		// Byte count is ignored on stripes that are not last.
		write_seed(32'h0000_0000);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd31, 1'b0);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd0, 1'b0);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd5, 1'b1);
		// New seed in the middle of a message: loaded lanes keep their values.
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd16, 1'b0);
		write_seed(32'h8000_0000);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd2, 1'b0);
		send_stripe($urandom(), $urandom(), $urandom(), $urandom(), 5'd13, 1'b1);
		// Zero stripe followed by an all-ones full closing stripe.
		send_stripe('0, '0, '0, '0, 5'd8, 1'b0);
		send_stripe('1, '1, '1, '1, 5'd16, 1'b1);
		send_stripe('0, '0, '0, '0, 5'd8, 1'b1);

		// Random messages, mostly short.
		write_seed($urandom());
		m = 0;
		while (beats_sent < 1450) begin
			if (m == 60)
				hold_req = 1'b1;
			if (m == 120)
				idling = 1'b0;
			if (m == 180)
				idling = 1'b1;
			if (m % 37 == 36) begin
				pick = $urandom_range(3);
				write_seed(pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF : $urandom());
			end
			pick = $urandom_range(99);
			if (pick < 70)
				nstr = $urandom_range(3);
			else if (pick < 95)
				nstr = $urandom_range(10, 4);
			else
				nstr = $urandom_range(24, 11);
			if ($urandom_range(9) == 0)
				cnt = 5'($urandom_range(31, 17));
			else
				cnt = 5'($urandom_range(16));
			send_message(nstr, cnt,
				(nstr > 0 && $urandom_range(99) < 3) ? $urandom_range(nstr, 1) : 0);
			m++;
		end
		stripe_if.valid <= 1'b0;

		// Drain, then allow for the longest tail.
		@(posedge clk);
		for (w = 0; w < 5000 && board.want_hash.size() != 0; w++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.want_hash.size() == 0) begin
			$display("xxh32_stream_hash_test: PASS");
		end else begin
			if (board.want_hash.size() != 0)
				$display("%0t: %0d expected hashes never arrived, next %h", $time,
					board.want_hash.size(), board.want_hash[0]);
			$display("xxh32_stream_hash_test: FAIL");
		end
		$finish;
	end

endmodule
